@@ rtl/page_cache_clock_replacement_core_defines.svh @@
// Assertion macros for the page cache replacement core.
`ifndef PAGE_CACHE_CLOCK_REPLACEMENT_CORE_DEFINES_SVH
`define PAGE_CACHE_CLOCK_REPLACEMENT_CORE_DEFINES_SVH
`ifndef SYNTH
`define PCCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PCCR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PCCR_ASSERT(lbl, prop, msg)
`define PCCR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ rtl/pccr_pkg.sv @@
// Shared types and constants for the page cache replacement core.
`default_nettype none
package pccr_pkg;

    localparam int PAGE_W  = 20;
    localparam int INDEX_W = 4;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_LOOKUP = 2'd0;
    localparam t_opcode OP_ALLOC  = 2'd1;
    localparam t_opcode OP_FILL   = 2'd2;
    localparam t_opcode OP_MARK   = 2'd3;

endpackage
`default_nettype wire

@@ rtl/page_cache_clock_replacement_core.sv @@
// Tag store and CLOCK / CLOCK-M victim selection for a small page cache.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: page_number, entry_index; tuser: opcode
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result_entry; tuser: hit, entry_was_free
//  cfg       in   i_cfg_wen                    i_cfg_wdata: replacement_mode
//
//  Fill and mark go from idle through their own state to the output state. Lookup reads
//  and then compares each entry in turn (S_LKRD, S_LKCMP), set by the single read port
//  of the page memory. Allocate checks each entry's valid flag in turn, then steps the
//  clock hand when no entry is free (up to 4 * ENTRIES steps in CLOCK-M).
//  Reset clears all flags at once; no clearing pass. One item at a time; the next
//  item is taken while the previous result waits in the output register.
`include "page_cache_clock_replacement_core_defines.svh"
`default_nettype none
module page_cache_clock_replacement_core #(
    parameter int ENTRIES   = 16,
    parameter int PAGE_BITS = 20
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wen,
    input  wire                  i_cfg_wdata,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [23:0]          s_axis_tdata,   // [19:0] page_number, [23:20] entry_index
    input  pccr_pkg::t_opcode    s_axis_tuser,   // [1:0] opcode
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [3:0] result_entry, [7:4] zero
    output logic [1:0]           m_axis_tuser    // [0] hit, [1] entry_was_free
);
    import pccr_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int XW = (IW > INDEX_W) ? IW : INDEX_W;
    localparam int PB = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int SW = $clog2(2 * ENTRIES + 1) + 1;
    localparam int CW = 9;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LKRD  = 3'd1;
    localparam logic [2:0] S_LKCMP = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_VICT  = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_MARK  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]         r_state;
    logic               r_mode;
    logic [PB-1:0]      r_key;
    logic [INDEX_W-1:0] r_eidx;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_hand;
    logic [SW-1:0]      r_step;
    logic [1:0]         r_pass;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_used;
    logic [ENTRIES-1:0] r_dirty;
    logic               r_hit;
    logic               r_free;
    logic [INDEX_W-1:0] r_res;
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_free;
    logic [INDEX_W-1:0] r_out_entry;

    logic [PB-1:0]      r_page_mem [ENTRIES];
    logic [PB-1:0]      r_rdata;

    logic               in_xfer;
    logic               out_free;
    logic [XW-1:0]      eidx_x;
    logic [IW-1:0]      eidx;
    logic               eidx_ok;
    logic               idx_last;
    logic               lk_hit;
    logic [IW-1:0]      hand_nxt;
    logic               vu;
    logic               vd;
    logic               v_found;
    logic               v_clear;
    logic               pass_end;
    logic               v_last;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign eidx_x   = XW'(r_eidx);
    assign eidx     = eidx_x[IW-1:0];
    assign eidx_ok  = CW'(r_eidx) < CW'(ENTRIES);
    assign idx_last = (r_idx == IW'(ENTRIES - 1));
    assign lk_hit   = r_valid[r_idx] && (r_rdata == r_key);
    assign hand_nxt = (r_hand == IW'(ENTRIES - 1)) ? '0 : r_hand + 1'b1;
    assign vu       = r_used[r_hand];
    assign vd       = r_dirty[r_hand];
    assign pass_end = (r_step == SW'(ENTRIES - 1));

    always_comb begin
        if (!r_mode) begin
            v_found = !vu;
            v_clear = vu;
            v_last  = (r_step == SW'(2 * ENTRIES));
        end else begin
            v_found = !vu && (vd == r_pass[0]);
            v_clear = r_pass[0] && !v_found;
            v_last  = pass_end && (r_pass == 2'd3);
        end
    end

    // page memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL && eidx_ok) begin
            r_page_mem[eidx] <= r_key;
        end
        r_rdata <= r_page_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_wen) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key  <= s_axis_tdata[PB-1:0];
            r_eidx <= s_axis_tdata[23:20];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_hand  <= '0;
            r_step  <= '0;
            r_pass  <= '0;
            r_valid <= '0;
            r_used  <= '0;
            r_dirty <= '0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_res   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_idx  <= '0;
                        r_hit  <= 1'b0;
                        r_free <= 1'b0;
                        r_res  <= s_axis_tdata[23:20];
                        case (s_axis_tuser)
                            OP_LOOKUP: r_state <= S_LKRD;
                            OP_ALLOC:  r_state <= S_ALLOC;
                            OP_FILL:   r_state <= S_FILL;
                            OP_MARK:   r_state <= S_MARK;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LKRD: begin
                    r_state <= S_LKCMP;
                end
                S_LKCMP: begin
                    if (lk_hit) begin
                        r_used[r_idx] <= 1'b1;
                        r_hit         <= 1'b1;
                        r_res         <= INDEX_W'(r_idx);
                        r_state       <= S_OUT;
                    end else if (idx_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_LKRD;
                    end
                end
                S_ALLOC: begin
                    if (!r_valid[r_idx]) begin
                        r_free  <= 1'b1;
                        r_res   <= INDEX_W'(r_idx);
                        r_state <= S_OUT;
                    end else if (idx_last) begin
                        r_step  <= '0;
                        r_pass  <= '0;
                        r_state <= S_VICT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_VICT: begin
                    r_hand <= hand_nxt;
                    if (v_found) begin
                        r_res   <= INDEX_W'(r_hand);
                        r_state <= S_OUT;
                    end else begin
                        if (v_clear) begin
                            r_used[r_hand] <= 1'b0;
                        end
                        if (v_last) begin
                            r_res   <= INDEX_W'(hand_nxt);
                            r_state <= S_OUT;
                        end else if (r_mode && pass_end) begin
                            r_step <= '0;
                            r_pass <= r_pass + 1'b1;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                S_FILL: begin
                    if (eidx_ok) begin
                        r_valid[eidx] <= 1'b1;
                        r_used[eidx]  <= 1'b1;
                        r_dirty[eidx] <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_MARK: begin
                    if (eidx_ok) begin
                        r_dirty[eidx] <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register: load the finished result, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_hit   <= r_hit;
            r_out_free  <= r_free;
            r_out_entry <= r_res;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_entry};
    assign m_axis_tuser  = {r_out_free, r_out_hit};

    `PCCR_ASSERT(a_accept_leaves_idle, in_xfer |=> (r_state != S_IDLE), "accepted item did not start")
    `PCCR_ASSERT(a_rise_from_out, $rose(m_axis_tvalid) |-> ($past(r_state) == S_OUT), "result without finish")
    `PCCR_ASSERT(a_hit_excl_free, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]), "hit and free both set")
    `PCCR_ASSERT(a_hit_sets_use, (r_state == S_LKCMP && lk_hit) |=> r_used[$past(r_idx)], "hit left use bit clear")
    `PCCR_ASSERT_RST(a_reset_no_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule
`default_nettype wire

@@ tb/page_cache_clock_replacement_core_tb.sv @@
// Self-checking testbench for the page cache tag store with CLOCK / CLOCK-M victim selection.
`default_nettype none
module page_cache_clock_replacement_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pccr_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic       hit;
        logic [3:0] entry;
        logic       was_free;
    } cache_result_t;

    class clock_cache_model;
        logic [PAGE_W-1:0] tag_page  [ENTRIES];
        bit                tag_valid [ENTRIES];
        bit                use_bit   [ENTRIES];
        bit                dirty_bit [ENTRIES];
        logic [3:0]        hand;
        bit                mode;
        cache_result_t     expected_results[$];
        int                errors;

        function new();
            hand   = '0;
            mode   = 1'b0;
            errors = 0;
            foreach (tag_valid[i]) begin
                tag_page[i]  = '0;
                tag_valid[i] = 1'b0;
                use_bit[i]   = 1'b0;
                dirty_bit[i] = 1'b0;
            end
        endfunction

        function logic [3:0] choose_victim();
            logic [3:0] v;
            if (!mode) begin
                for (int i = 0; i < 2 * ENTRIES + 1; i++) begin
                    v = hand;
                    hand++;
                    if (!use_bit[v]) return v;
                    use_bit[v] = 1'b0;
                end
                return hand;
            end
            for (int p = 0; p < 2; p++) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    v = hand;
                    hand++;
                    if (!use_bit[v] && !dirty_bit[v]) return v;
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    v = hand;
                    hand++;
                    if (!use_bit[v] && dirty_bit[v]) return v;
                    use_bit[v] = 1'b0;
                end
            end
            return hand;
        endfunction

        function cache_result_t note_request(t_opcode op, logic [PAGE_W-1:0] page,
                                             logic [3:0] idx);
            cache_result_t r;
            bit            found;
            r.hit      = 1'b0;
            r.entry    = idx;
            r.was_free = 1'b0;
            found      = 1'b0;
            case (op)
                OP_LOOKUP: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!found && tag_valid[i] && tag_page[i] == page) begin
                            found      = 1'b1;
                            use_bit[i] = 1'b1;
                            r.hit      = 1'b1;
                            r.entry    = 4'(i);
                        end
                    end
                end
                OP_ALLOC: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!found && !tag_valid[i]) begin
                            found      = 1'b1;
                            r.entry    = 4'(i);
                            r.was_free = 1'b1;
                        end
                    end
                    if (!found) r.entry = choose_victim();
                end
                OP_FILL: begin
                    tag_page[idx]  = page;
                    tag_valid[idx] = 1'b1;
                    use_bit[idx]   = 1'b1;
                    dirty_bit[idx] = 1'b0;
                end
                default: begin
                    dirty_bit[idx] = 1'b1;
                end
            endcase
            expected_results.push_back(r);
            return r;
        endfunction

        function void check_response(cache_result_t got);
            cache_result_t exp_r;
            if (expected_results.size() == 0) begin
                $error("result with no pending request: hit=%0d result_entry=%0d entry_was_free=%0d",
                       got.hit, got.entry, got.was_free);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.hit !== exp_r.hit) begin
                $error("hit: expected %0d, actual %0d", exp_r.hit, got.hit);
                errors++;
            end
            if (got.entry !== exp_r.entry) begin
                $error("result_entry: expected %0d, actual %0d", exp_r.entry, got.entry);
                errors++;
            end
            if (got.was_free !== exp_r.was_free) begin
                $error("entry_was_free: expected %0d, actual %0d", exp_r.was_free, got.was_free);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wen     = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // [19:0] page_number, [23:20] entry_index
    t_opcode     s_axis_tuser  = OP_LOOKUP;    // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [3:0] result_entry, [7:4] zero
    logic [1:0]  m_axis_tuser;          // [0] hit, [1] entry_was_free

    clock_cache_model  model;
    bit                steady = 1'b0;
    int                sent   = 0;
    int                cycles = 0;
    logic [PAGE_W-1:0] page_pool[POOL_SIZE];

    page_cache_clock_replacement_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL page_cache_clock_replacement_core");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            model.check_response({m_axis_tuser[0], m_axis_tdata[3:0], m_axis_tuser[1]});
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin : result_side
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (steady) begin
                hold = 0;
                m_axis_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    task automatic send_item(input t_opcode op, input logic [PAGE_W-1:0] page,
                             input logic [3:0] idx, output cache_result_t pred);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, page};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = model.note_request(op, page, idx);
        sent++;
    endtask

    task automatic sender_gap();
        int n;
        n = steady ? 0 : pick_gap();
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain(input int settle);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit m);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        model.mode = m;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    task automatic issue(input t_opcode op, input logic [PAGE_W-1:0] page, input logic [3:0] idx);
        cache_result_t unused;
        sender_gap();
        send_item(op, page, idx, unused);
    endtask

    // lookup, then on a miss allocate and usually fill the chosen slot; on a hit sometimes mark it
    task automatic access_page(input logic [PAGE_W-1:0] page);
        cache_result_t got;
        logic [3:0]    slot;
        sender_gap();
        send_item(OP_LOOKUP, page, 4'($urandom), got);
        slot = got.entry;
        if (got.hit) begin
            if ($urandom_range(0, 99) < 30) issue(OP_MARK, PAGE_W'($urandom), slot);
        end else begin
            sender_gap();
            send_item(OP_ALLOC, PAGE_W'($urandom), 4'($urandom), got);
            slot = got.entry;
            if ($urandom_range(0, 9) != 0) issue(OP_FILL, page, slot);
        end
    endtask

    initial begin : stimulus
        bit            mode_plan[PHASES];
        int            target;

        model = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(OP_LOOKUP, '0, 4'hF);
        issue(OP_ALLOC, 20'hFFFFF, 4'h0);
        issue(OP_FILL, 20'hFFFFF, 4'h0);
        issue(OP_FILL, '0, 4'hF);
        issue(OP_MARK, '0, 4'hF);
        issue(OP_MARK, 20'hFFFFF, 4'h3);
        issue(OP_LOOKUP, 20'hFFFFF, 4'h0);
        issue(OP_LOOKUP, '0, 4'h7);
        issue(OP_ALLOC, '0, 4'hF);
        for (int i = 1; i < ENTRIES - 1; i++) issue(OP_FILL, PAGE_W'(i * 20'h11111), 4'(i));
        issue(OP_ALLOC, '0, '0);
        issue(OP_LOOKUP, 20'h12345, 4'h8);
        drain(8);
        write_mode(1'b1);
        issue(OP_ALLOC, '0, '0);
        issue(OP_ALLOC, '0, '0);

        page_pool[0] = '0;
        page_pool[1] = 20'hFFFFF;
        for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom);
        mode_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

        for (int ph = 0; ph < PHASES; ph++) begin
            drain(8);
            write_mode(mode_plan[ph]);
            steady = (ph == 2);
            target = sent + PHASE_ITEMS;
            while (sent < target) begin
                if ($urandom_range(0, 9) == 0)
                    page_pool[$urandom_range(2, POOL_SIZE - 1)] = PAGE_W'($urandom);
                if ($urandom_range(0, 99) < 70) begin
                    access_page(page_pool[$urandom_range(0, POOL_SIZE - 1)]);
                end else begin
                    issue(t_opcode'($urandom), PAGE_W'($urandom), 4'($urandom));
                end
                if ($urandom_range(0, 199) == 0) drain(0);
            end
        end
        steady = 1'b0;

        drain(100);
        if (model.errors == 0 && model.pending() == 0) begin
            $display("PASS page_cache_clock_replacement_core");
        end else begin
            $display("FAIL page_cache_clock_replacement_core");
        end
        $finish;
    end
endmodule
`default_nettype wire
